>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks sampled on clk, held off while rst_n is low.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks sampled on clk at every rising edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> design/rlqe_pkg.sv
`default_nettype none
package rlqe_pkg;
  localparam int NODE_W    = 12;
  localparam int DEPTH_W   = 12;
  localparam int SUMDEP_W  = DEPTH_W + 1;
  localparam int DIST_W    = DEPTH_W + 3;
  localparam int SCORE_W   = DEPTH_W + 4;
  localparam int NUM_CAND  = 6;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
  localparam logic CMD_ATTACH = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ATT_RDDEP,
    ST_ATT_WRDEP,
    ST_ATT_RD,
    ST_ATT_WR,
    ST_JOB,
    ST_L_DA,
    ST_L_DB,
    ST_L_SW,
    ST_P1_RA,
    ST_P1_RD,
    ST_P1_CMP,
    ST_EQ,
    ST_P2_RA,
    ST_P2_RB,
    ST_P2_CMP,
    ST_FIN_RA,
    ST_FIN,
    ST_M_DEP,
    ST_M_GOT,
    ST_DONE
  } rlqe_state_t;
endpackage
`default_nettype wire

>>> design/rlqe_if.sv
`default_nettype none
interface rlqe_in_if;
  import rlqe_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [NODE_W-1:0] first_node;
  logic [NODE_W-1:0] second_node;
  logic [NODE_W-1:0] root_node;
  modport source (output valid, command, first_node, second_node, root_node, input ready);
  modport sink (input valid, command, first_node, second_node, root_node, output ready);
endinterface

interface rlqe_out_if;
  import rlqe_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] answer_node;
  modport source (output valid, answer_node, input ready);
  modport sink (input valid, answer_node, output ready);
endinterface
`default_nettype wire

>>> design/rerooted_lca_query_engine_top.sv
// Attach: a depth read and write, then a read and write per higher level; no result.
// Query: 21 LCA walks over the shared ancestor RAM read port (three for the
// candidate LCAs, then three per candidate for its score) before the result.
// One request in flight at a time; a finished answer waits in the output register.
// Reset (synchronous, rst_n low) starts a clearing pass over all depth RAM
// entries during which no request is taken.
`default_nettype none
`include "assert_macros.svh"
module rerooted_lca_query_engine_top
  import rlqe_pkg::*;
#(
  parameter int NODES  = 4096,
  parameter int LEVELS = 12
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rlqe_in_if.sink   in_ch,
  rlqe_out_if.source out_ch
);
  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LB = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW = NW + LB;
  localparam int ANC_DEPTH = 1 << AW;
  localparam logic [LB-1:0] LVL_TOP = LB'(LEVELS - 1);

  rlqe_state_t state_r, state_nxt;

  logic [NW-1:0]      clr_r;
  logic [NW-1:0]      cand_r [NUM_CAND];
  logic [NW-1:0]      la_r, lb_r, t_r, ta_r, m_r, cur_r, best_r;
  logic [DEPTH_W-1:0] da_r, db_r;
  logic [SUMDEP_W-1:0] sumdep_r;
  logic [LB-1:0]      lvl_r;
  logic               z_r;
  logic               pre_r;
  logic [1:0]         job_r;
  logic [2:0]         k_r;
  logic [1:0]         j_r;
  logic signed [SCORE_W-1:0] acc_r, best_score_r;
  logic               out_valid_r;
  logic [NODE_W-1:0]  ans_r;

  logic               dep_we;
  logic [NW-1:0]      dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0] dep_wdata, dep_rdata;
  logic               anc_we;
  logic [AW-1:0]      anc_waddr, anc_raddr;
  logic [NODE_W-1:0]  anc_wdata, anc_rdata;

  logic [NW-1:0]      anc_node;
  logic [NW-1:0]      opx, opy;
  logic [DEPTH_W-1:0] new_depth;
  logic signed [DIST_W-1:0]  dist_s;
  logic signed [SCORE_W-1:0] score_s;
  logic               accept;

  function automatic logic [NW-1:0] clip(input logic [NODE_W-1:0] x);
    logic [NW-1:0] y;
    y = '0;
    if (32'(x) < NODES) begin
      y = NW'(x);
    end
    return y;
  endfunction

  rlqe_ram #(.WIDTH(DEPTH_W), .DEPTH(NODES)) u_depth_ram (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .raddr(dep_raddr), .rdata(dep_rdata)
  );

  rlqe_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc_ram (
    .clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
    .raddr(anc_raddr), .rdata(anc_rdata)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign accept             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.answer_node = ans_r;

  // node 0 rows are never written: force the sentinel
  assign anc_node  = z_r ? '0 : clip(anc_rdata);
  assign new_depth = (cand_r[1] == '0) ? DEPTH_W'(1) :
                     (dep_rdata == DEPTH_MAX) ? DEPTH_MAX : dep_rdata + DEPTH_W'(1);
  assign dist_s  = $signed({2'b00, sumdep_r}) - $signed({2'b00, dep_rdata, 1'b0});
  assign score_s = acc_r + SCORE_W'(dist_s);

  always_comb begin
    opx = cand_r[k_r];
    unique case (j_r)
      2'd0:    opy = cand_r[2];
      2'd1:    opy = cand_r[0];
      default: opy = cand_r[1];
    endcase
    if (pre_r) begin
      unique case (job_r)
        2'd0:    begin opx = cand_r[2]; opy = cand_r[0]; end
        2'd1:    begin opx = cand_r[2]; opy = cand_r[1]; end
        default: begin opx = cand_r[0]; opy = cand_r[1]; end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    dep_we    = 1'b0;
    dep_waddr = cand_r[0];
    dep_wdata = new_depth;
    dep_raddr = la_r;
    anc_we    = 1'b0;
    anc_waddr = {cand_r[0], lvl_r};
    anc_wdata = NODE_W'(anc_node);
    anc_raddr = {la_r, lvl_r};
    unique case (state_r)
      ST_CLEAR: begin
        dep_we    = 1'b1;
        dep_waddr = clr_r;
        dep_wdata = '0;
        if (clr_r == NW'(NODES - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.command == CMD_QUERY) state_nxt = ST_JOB;
          else if (clip(in_ch.first_node) == '0) state_nxt = ST_IDLE;
          else state_nxt = ST_ATT_RDDEP;
        end
      end
      ST_ATT_RDDEP: begin
        dep_raddr = cand_r[1];
        state_nxt = ST_ATT_WRDEP;
      end
      ST_ATT_WRDEP: begin
        dep_we    = 1'b1;
        anc_we    = 1'b1;
        anc_waddr = {cand_r[0], LB'(0)};
        anc_wdata = NODE_W'(cand_r[1]);
        state_nxt = (LEVELS > 1) ? ST_ATT_RD : ST_IDLE;
      end
      ST_ATT_RD: begin
        anc_raddr = {cur_r, lvl_r - LB'(1)};
        state_nxt = ST_ATT_WR;
      end
      ST_ATT_WR: begin
        anc_we    = 1'b1;
        state_nxt = (lvl_r == LVL_TOP) ? ST_IDLE : ST_ATT_RD;
      end
      ST_JOB:   state_nxt = ST_L_DA;
      ST_L_DA: begin
        dep_raddr = la_r;
        state_nxt = ST_L_DB;
      end
      ST_L_DB: begin
        dep_raddr = lb_r;
        state_nxt = ST_L_SW;
      end
      ST_L_SW:  state_nxt = ST_P1_RA;
      ST_P1_RA: state_nxt = ST_P1_RD;
      ST_P1_RD: begin
        dep_raddr = anc_node;
        state_nxt = ST_P1_CMP;
      end
      ST_P1_CMP: state_nxt = (lvl_r == '0) ? ST_EQ : ST_P1_RA;
      ST_EQ:     state_nxt = (la_r == lb_r) ? ST_M_DEP : ST_P2_RA;
      ST_P2_RA:  state_nxt = ST_P2_RB;
      ST_P2_RB: begin
        anc_raddr = {lb_r, lvl_r};
        state_nxt = ST_P2_CMP;
      end
      ST_P2_CMP: state_nxt = (lvl_r == '0) ? ST_FIN_RA : ST_P2_RA;
      ST_FIN_RA: begin
        anc_raddr = {la_r, LB'(0)};
        state_nxt = ST_FIN;
      end
      ST_FIN:   state_nxt = ST_M_DEP;
      ST_M_DEP: begin
        dep_raddr = m_r;
        state_nxt = ST_M_GOT;
      end
      ST_M_GOT: begin
        if (!pre_r && j_r == 2'd2 && k_r == 3'(NUM_CAND - 1)) state_nxt = ST_DONE;
        else state_nxt = ST_JOB;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + NW'(1);
      if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cand_r[0] <= clip(in_ch.first_node);
          cand_r[1] <= clip(in_ch.second_node);
          cand_r[2] <= clip(in_ch.root_node);
          pre_r     <= 1'b1;
          job_r     <= '0;
        end
      end
      ST_ATT_WRDEP: begin
        cur_r <= cand_r[1];
        lvl_r <= LB'(1);
      end
      ST_ATT_RD: z_r <= (cur_r == '0);
      ST_ATT_WR: begin
        cur_r <= anc_node;
        lvl_r <= lvl_r + LB'(1);
      end
      ST_JOB: begin
        la_r <= opx;
        lb_r <= opy;
      end
      ST_L_DB: da_r <= dep_rdata;
      ST_L_SW: begin
        sumdep_r <= {1'b0, da_r} + {1'b0, dep_rdata};
        lvl_r    <= LVL_TOP;
        if (da_r < dep_rdata) begin
          la_r <= lb_r;
          lb_r <= la_r;
          db_r <= da_r;
        end else begin
          db_r <= dep_rdata;
        end
      end
      ST_P1_RA: z_r <= (la_r == '0);
      ST_P1_RD: t_r <= anc_node;
      ST_P1_CMP: begin
        if (dep_rdata >= db_r) la_r <= t_r;
        lvl_r <= lvl_r - LB'(1);
      end
      ST_EQ: begin
        m_r   <= la_r;
        lvl_r <= LVL_TOP;
      end
      ST_P2_RA: z_r <= (la_r == '0);
      ST_P2_RB: begin
        ta_r <= anc_node;
        z_r  <= (lb_r == '0);
      end
      ST_P2_CMP: begin
        if (ta_r != anc_node) begin
          la_r <= ta_r;
          lb_r <= anc_node;
        end
        lvl_r <= lvl_r - LB'(1);
      end
      ST_FIN_RA: z_r <= (la_r == '0);
      ST_FIN:    m_r <= anc_node;
      ST_M_GOT: begin
        if (pre_r) begin
          cand_r[3'd3 + {1'b0, job_r}] <= m_r;
          if (job_r == 2'd2) begin
            pre_r <= 1'b0;
            k_r   <= '0;
            j_r   <= '0;
            acc_r <= '0;
          end else begin
            job_r <= job_r + 2'd1;
          end
        end else if (j_r == 2'd2) begin
          // ties go to the smaller node id
          if (k_r == '0 || score_s < best_score_r ||
              (score_s == best_score_r && cand_r[k_r] < best_r)) begin
            best_r       <= cand_r[k_r];
            best_score_r <= score_s;
          end
          acc_r <= '0;
          j_r   <= '0;
          k_r   <= k_r + 3'd1;
        end else begin
          acc_r <= score_s;
          j_r   <= j_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) ans_r <= NODE_W'(best_r);
      end
      default: ;
    endcase
  end

  `ASSERT_RST(a_no_request_in_clear, (state_r == ST_CLEAR) |-> !in_ch.ready, "request taken during clear")
  `ASSERT_RST(a_sentinel_untouched, anc_we |-> (anc_waddr[AW-1:LB] != '0), "write to sentinel row")
  `ASSERT_RST(a_result_waits, (state_r == ST_DONE && out_valid_r && !out_ch.ready) |=> (state_r == ST_DONE), "result dropped")
endmodule
`default_nettype wire

>>> design/rlqe_ram.sv
`default_nettype none
module rlqe_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> sim/rlqe_checker.sv
`timescale 1ns / 1ps
module rlqe_checker
  import rlqe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rlqe_in_if   in_ch,
  rlqe_out_if  out_ch,
  output int   fail_count,
  output int   answers_waiting,
  output int   attach_count,
  output int   answers_checked
);
  logic [NODE_W-1:0]  anc_tbl [0:4095][0:11];
  logic [DEPTH_W-1:0] depth_tbl [0:4095];
  logic [NODE_W-1:0]  answer_q [$];

  initial begin
    fail_count = 0;
    attach_count = 0;
    answers_checked = 0;
    for (int n = 0; n < 4096; n++) begin
      depth_tbl[n] = '0;
      for (int l = 0; l < 12; l++) anc_tbl[n][l] = '0;
    end
  end

  assign answers_waiting = answer_q.size();

  function automatic logic [NODE_W-1:0] hop(logic [NODE_W-1:0] x, int l);
    if (x == 0) return '0;
    return anc_tbl[x][l];
  endfunction

  function automatic int depth_of(logic [NODE_W-1:0] x);
    if (x == 0) return 0;
    return depth_tbl[x];
  endfunction

  function automatic logic [NODE_W-1:0] common_anc(logic [NODE_W-1:0] a,
                                                     logic [NODE_W-1:0] b);
    logic [NODE_W-1:0] t;
    if (depth_of(a) < depth_of(b)) begin
      t = a; a = b; b = t;
    end
    for (int i = 11; i >= 0; i--)
      if (depth_of(hop(a, i)) >= depth_of(b)) a = hop(a, i);
    if (a == b) return a;
    for (int i = 11; i >= 0; i--)
      if (hop(a, i) != hop(b, i)) begin
        a = hop(a, i);
        b = hop(b, i);
      end
    return hop(a, 0);
  endfunction

  function automatic int tree_dist(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    return depth_of(a) + depth_of(b) - 2 * depth_of(common_anc(a, b));
  endfunction

  function automatic logic [NODE_W-1:0] rerooted_lca(logic [NODE_W-1:0] u,
                                                       logic [NODE_W-1:0] v,
                                                       logic [NODE_W-1:0] r);
    logic [NODE_W-1:0] cand [NUM_CAND];
    logic [NODE_W-1:0] best;
    int best_score, s;
    cand[0] = u;
    cand[1] = v;
    cand[2] = r;
    cand[3] = common_anc(r, u);
    cand[4] = common_anc(r, v);
    cand[5] = common_anc(u, v);
    best = '0;
    best_score = 0;
    for (int i = 0; i < NUM_CAND; i++) begin
      s = tree_dist(cand[i], r) + tree_dist(cand[i], u) + tree_dist(cand[i], v);
      if (i == 0 || s < best_score || (s == best_score && cand[i] < best)) begin
        best = cand[i];
        best_score = s;
      end
    end
    return best;
  endfunction

  task automatic attach_node(logic [NODE_W-1:0] a, logic [NODE_W-1:0] p);
    int d;
    if (a == 0) return;
    d = (p == 0) ? 1 : depth_of(p) + 1;
    if (d > int'(DEPTH_MAX)) d = int'(DEPTH_MAX);
    depth_tbl[a] = DEPTH_W'(d);
    anc_tbl[a][0] = p;
    for (int i = 1; i < 12; i++) anc_tbl[a][i] = hop(hop(a, i - 1), i - 1);
  endtask

  logic [NODE_W-1:0] want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == CMD_ATTACH) begin
          attach_node(in_ch.first_node, in_ch.second_node);
          attach_count++;
        end else begin
          answer_q = {answer_q, rerooted_lca(in_ch.first_node, in_ch.second_node,
                                             in_ch.root_node)};
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected answer %0d", $time, out_ch.answer_node);
        end else begin
          want = answer_q.pop_front();
          answers_checked++;
          if (out_ch.answer_node !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: answer_node expected %0d got %0d", $time, want,
                       out_ch.answer_node);
          end
        end
      end
    end
  end
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rlqe_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, answers_waiting, attach_count, answers_checked;
  bit   busy_mode;
  bit   attached [0:4095];
  logic [NODE_W-1:0] known_q [$];

  rlqe_in_if  in_ch ();
  rlqe_out_if out_ch ();

  rerooted_lca_query_engine_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rlqe_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .answers_waiting (answers_waiting),
    .attach_count    (attach_count),
    .answers_checked (answers_checked)
  );

  always #6 clk = ~clk;

  initial begin
    #(12 * 40_000_000);
    $display("tb_top failed");
    $finish;
  end

  function automatic int gap_len();
    int p;
    if (busy_mode) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls plus one long hold-off so the input backs up
  initial begin
    int cyc;
    cyc = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 100000) begin
        out_ch.ready <= 1'b0;
        repeat (12000) @(negedge clk);
        cyc++;
      end else if ($urandom_range(99) < 8) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 30) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) < 75);
      end
    end
  end

  task automatic send_request(logic cmd, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                              logic [NODE_W-1:0] r);
    int g;
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.first_node  <= a;
    in_ch.second_node <= b;
    in_ch.root_node   <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_ATTACH && a != 0 && !attached[a]) begin
      attached[a] = 1'b1;
      known_q = {known_q, a};
    end
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic attach(logic [NODE_W-1:0] a, logic [NODE_W-1:0] p);
    send_request(CMD_ATTACH, a, p, NODE_W'($urandom()));
  endtask

  task automatic query(logic [NODE_W-1:0] u, logic [NODE_W-1:0] v, logic [NODE_W-1:0] r);
    send_request(CMD_QUERY, u, v, r);
  endtask

  // an attached node or, now and then, the sentinel 0
  function automatic logic [NODE_W-1:0] pick_known();
    if (known_q.size() == 0 || $urandom_range(15) == 0) return '0;
    return known_q[$urandom_range(known_q.size() - 1)];
  endfunction

  initial begin
    int n_items, waited;
    logic [NODE_W-1:0] a;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ATTACH;
    in_ch.first_node = '0;
    in_ch.second_node = '0;
    in_ch.root_node = '0;
    for (int i = 0; i < 4096; i++) attached[i] = 1'b0;
    busy_mode = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    attach(1, 0);
    attach(2, 1);
    attach(3, 1);
    attach(4095, 2);
    attach(2048, 4095);
    attach(0, 1);            // sentinel, ignored
    attach(7, 7);            // self parent
    query(4095, 3, 1);
    query(2048, 3, 2);
    query(0, 0, 0);
    query(4095, 4095, 4095);
    query(0, 2048, 1);
    query(7, 1, 7);
    query(3, 2048, 4095);
    attach(3, 2048);         // re-attach below its old sibling
    query(3, 4095, 1);
    query(1, 2, 3);
    attach(2, 3);            // now a cycle
    query(2, 3, 2048);
    query(4095, 1, 2);

    // ping-pong re-attach drives depths up without a real tree
    attach(4093, 0);
    attach(4094, 4093);
    for (int i = 0; i < 200; i++) begin
      attach(4093, 4094);
      attach(4094, 4093);
    end
    query(4093, 4094, 1);
    query(4094, 1, 4093);
    query(0, 4094, 4093);

    // random: mostly tree growth and queries on loaded nodes
    n_items = 0;
    while (n_items < 1570) begin
      if ($urandom_range(199) == 0) busy_mode = ~busy_mode;
      if ($urandom_range(99) < 40) begin
        a = NODE_W'($urandom_range(1, 4095));
        if ($urandom_range(20) == 0 && known_q.size() > 0) a = pick_known();
        attach(a, pick_known());
        if (a != 0) n_items++;
      end else begin
        query(pick_known(), pick_known(), pick_known());
        n_items++;
      end
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (answers_waiting != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (100) @(negedge clk);
    $display("attaches %0d, rerooted queries checked %0d, nodes loaded %0d",
             attach_count, answers_checked, known_q.size());
    if (fail_count == 0 && answers_waiting == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/rlqe_pkg.sv
design/rlqe_if.sv
design/rlqe_ram.sv
design/rerooted_lca_query_engine_top.sv
sim/rlqe_checker.sv
sim/tb_top.sv
